FILE: src/conv2d_pkg.sv
// ----------------------------------------------------------------------------
// conv2d_pkg
// Shared types, sizes and address helpers for the 3x3 same-padded
// multichannel convolution block.
// ----------------------------------------------------------------------------
package conv2d_pkg;

    // Kernel and storage geometry
    localparam int KERNEL_WIDTH    = 3;
    localparam int KERNEL_HEIGHT   = 3;
    localparam int MAX_WIDTH       = 32;
    localparam int MAX_HEIGHT      = 32;
    localparam int MAX_IN_CHANNELS = 64;
    localparam int MAX_FILTERS     = 64;

    localparam int TAPS      = KERNEL_WIDTH * KERNEL_HEIGHT;
    localparam int KW_HALF   = KERNEL_WIDTH / 2;
    localparam int KH_HALF   = KERNEL_HEIGHT / 2;
    localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WGT_DEPTH = MAX_FILTERS * MAX_IN_CHANNELS * TAPS;
    localparam int IMG_AW    = $clog2(IMG_DEPTH);
    localparam int WGT_AW    = $clog2(WGT_DEPTH);

    // Datapath widths
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 42;

    // Item kinds
    localparam logic [1:0] KIND_WR_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_WR_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_COMPUTE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_IN_CHANNELS  = 2'd2;
    localparam logic [1:0] CFG_NUM_FILTERS  = 2'd3;

    // Register reset values
    localparam logic [5:0] RST_IMAGE_WIDTH  = 6'd32;
    localparam logic [5:0] RST_IMAGE_HEIGHT = 6'd32;
    localparam logic [6:0] RST_IN_CHANNELS  = 7'd3;
    localparam logic [6:0] RST_NUM_FILTERS  = 7'd64;

    typedef struct packed {
        logic [1:0]               kind;
        logic [5:0]               channel;
        logic [5:0]               filter_index;
        logic [4:0]               row;
        logic [4:0]               col;
        logic [1:0]               tap_row;
        logic [1:0]               tap_col;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] out_value;
        logic [5:0]              out_filter;
        logic [4:0]              out_row;
        logic [4:0]              out_col;
        logic                    bad_request;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Store write request
    typedef struct packed {
        logic              img_we;
        logic              wgt_we;
        logic [IMG_AW-1:0] img_addr;
        logic [WGT_AW-1:0] wgt_addr;
        logic [DATA_W-1:0] data;
    } t_mem_wr;

    // Store read addresses
    typedef struct packed {
        logic [IMG_AW-1:0] img_addr;
        logic [WGT_AW-1:0] wgt_addr;
    } t_mem_rd;

    // Multiply-accumulate control
    typedef struct packed {
        logic clear;
        logic valid;
    } t_mac_ctl;

    // Saturate a raw size register to the range 1..maxv
    function automatic logic [6:0] eff_size(input logic [6:0] raw, input int maxv);
        logic [6:0] res;
        if (raw == 7'd0) begin
            res = 7'd1;
        end else if (int'(raw) > maxv) begin
            res = 7'(maxv);
        end else begin
            res = raw;
        end
        return res;
    endfunction

    // Kernel position to linear tap number
    function automatic logic [3:0] tap_index(input logic [1:0] tr, input logic [1:0] tc);
        return 4'(tr) * 4'(KERNEL_WIDTH) + 4'(tc);
    endfunction

    // Channel-planar pixel address
    function automatic logic [IMG_AW-1:0] img_addr(input logic [5:0] ch,
                                                   input logic [4:0] r,
                                                   input logic [4:0] c);
        return IMG_AW'({ch, r, c});
    endfunction

    // Weight address: filter, channel, then tap
    function automatic logic [WGT_AW-1:0] wgt_addr(input logic [5:0] f,
                                                   input logic [5:0] ch,
                                                   input logic [3:0] tap);
        return WGT_AW'({f, ch}) * WGT_AW'(TAPS) + WGT_AW'(tap);
    endfunction

endpackage

FILE: src/conv2d_store.sv
// ----------------------------------------------------------------------------
// conv2d_store
// Pixel and weight memories, one write port and one registered read port
// each.
// ----------------------------------------------------------------------------
module conv2d_store (
    input  logic                           i_clk,
    input  conv2d_pkg::t_mem_wr            i_wr,
    input  conv2d_pkg::t_mem_rd            i_rd,
    output logic [conv2d_pkg::DATA_W-1:0]  o_img_q,
    output logic [conv2d_pkg::DATA_W-1:0]  o_wgt_q
);

    logic [conv2d_pkg::DATA_W-1:0] r_img_mem [conv2d_pkg::IMG_DEPTH];
    logic [conv2d_pkg::DATA_W-1:0] r_wgt_mem [conv2d_pkg::WGT_DEPTH];
    logic [conv2d_pkg::DATA_W-1:0] r_img_q;
    logic [conv2d_pkg::DATA_W-1:0] r_wgt_q;

    // Image plane memory
    always_ff @(posedge i_clk) begin
        if (i_wr.img_we) begin
            r_img_mem[i_wr.img_addr] <= i_wr.data;
        end
        r_img_q <= r_img_mem[i_rd.img_addr];
    end

    // Kernel weight memory
    always_ff @(posedge i_clk) begin
        if (i_wr.wgt_we) begin
            r_wgt_mem[i_wr.wgt_addr] <= i_wr.data;
        end
        r_wgt_q <= r_wgt_mem[i_rd.wgt_addr];
    end

    assign o_img_q = r_img_q;
    assign o_wgt_q = r_wgt_q;

endmodule

FILE: src/conv2d_mac.sv
// ----------------------------------------------------------------------------
// conv2d_mac
// Shared multiply-accumulate unit: one registered 16x16 product and one
// 42-bit accumulate per cycle.
// ----------------------------------------------------------------------------
module conv2d_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  conv2d_pkg::t_mac_ctl                 i_ctl,
    input  logic [conv2d_pkg::DATA_W-1:0]        i_pixel,
    input  logic [conv2d_pkg::DATA_W-1:0]        i_weight,
    output logic signed [conv2d_pkg::ACC_W-1:0] o_acc,
    output logic                                 o_busy
);

    logic signed [conv2d_pkg::PROD_W-1:0] prod_c;
    logic signed [conv2d_pkg::PROD_W-1:0] r_prod;
    logic                                 r_prod_valid;
    logic signed [conv2d_pkg::ACC_W-1:0]  r_acc;

    // Q4.12 times Q4.12 gives Q8.24
    assign prod_c = conv2d_pkg::PROD_W'(signed'(i_pixel))
                  * conv2d_pkg::PROD_W'(signed'(i_weight));

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid;
        end
        r_prod <= prod_c;
    end

    // Accumulate stage; the sum of at most 576 products stays inside 42 bits
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_valid) begin
            r_acc <= r_acc + conv2d_pkg::ACC_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_prod_valid;

endmodule

FILE: src/conv2d_same_multichannel.sv
// ----------------------------------------------------------------------------
// conv2d_same_multichannel
// 3x3 same-padded convolution over several input channels, summed by one
// shared multiply-accumulate unit under a tap sequencer.
// ----------------------------------------------------------------------------
//
//   channel   signals                          direction
//   -------   ------------------------------   ---------
//   in        i_in_valid  o_in_stall  i_in_item    in
//   out       o_out_valid i_out_stall o_out_item   out
//   cfg       i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data   in
//
// A compute request steps through in_channels * 9 taps, one
// multiply-accumulate per cycle, and then passes the memory read, product
// and accumulate stages and the result load; taps off the image still
// take their turn but add no product. An out-of-range request goes
// straight to the done state. i_rst_n is synchronous; the memories are not
// cleared. A finished result waits in the output register while the next
// item is taken; a new result waits in the done state until that register
// is free.
// ----------------------------------------------------------------------------
module conv2d_same_multichannel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  conv2d_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output conv2d_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [6:0]            i_cfg_data
);

    // Configuration registers
    logic [5:0] r_image_width;
    logic [5:0] r_image_height;
    logic [6:0] r_in_channels;
    logic [6:0] r_num_filters;

    // Effective sizes
    logic [5:0] w_eff;
    logic [5:0] h_eff;
    logic [6:0] nc_eff;
    logic [6:0] nf_eff;

    // Sequencer state
    conv2d_pkg::t_state r_state, n_state;
    logic [5:0] r_chan, n_chan;
    logic [1:0] r_ki, n_ki;
    logic [1:0] r_kj, n_kj;
    logic [3:0] r_tap, n_tap;
    logic       r_drain, n_drain;
    logic [5:0] r_req_filter, n_req_filter;
    logic [4:0] r_req_row, n_req_row;
    logic [4:0] r_req_col, n_req_col;
    logic       r_bad, n_bad;
    logic       r_p1_valid;
    logic       r_out_valid, n_out_valid;
    conv2d_pkg::t_out_item r_out, n_out;

    logic                  in_accept;
    logic                  issue;
    logic                  req_bad;
    logic [6:0]            pr;
    logic [6:0]            pc;
    logic                  tap_ok;
    logic                  last_tap;
    logic                  last_chan;
    conv2d_pkg::t_mem_wr   mem_wr;
    conv2d_pkg::t_mem_rd   mem_rd;
    conv2d_pkg::t_mac_ctl  mac_ctl;
    logic [conv2d_pkg::DATA_W-1:0]        img_q;
    logic [conv2d_pkg::DATA_W-1:0]        wgt_q;
    logic signed [conv2d_pkg::ACC_W-1:0]  mac_acc;
    logic                                 mac_busy;

    // Configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= conv2d_pkg::RST_IMAGE_WIDTH;
            r_image_height <= conv2d_pkg::RST_IMAGE_HEIGHT;
            r_in_channels  <= conv2d_pkg::RST_IN_CHANNELS;
            r_num_filters  <= conv2d_pkg::RST_NUM_FILTERS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                conv2d_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[5:0];
                conv2d_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[5:0];
                conv2d_pkg::CFG_IN_CHANNELS:  r_in_channels  <= i_cfg_data;
                conv2d_pkg::CFG_NUM_FILTERS:  r_num_filters  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes to 1..max
    assign w_eff  = 6'(conv2d_pkg::eff_size({1'b0, r_image_width}, conv2d_pkg::MAX_WIDTH));
    assign h_eff  = 6'(conv2d_pkg::eff_size({1'b0, r_image_height}, conv2d_pkg::MAX_HEIGHT));
    assign nc_eff = conv2d_pkg::eff_size(r_in_channels, conv2d_pkg::MAX_IN_CHANNELS);
    assign nf_eff = conv2d_pkg::eff_size(r_num_filters, conv2d_pkg::MAX_FILTERS);

    // Input handshake
    assign o_in_stall = (r_state != conv2d_pkg::S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Direct writes into the stores
    always_comb begin
        mem_wr.data     = i_in_item.value;
        mem_wr.img_addr = conv2d_pkg::img_addr(i_in_item.channel, i_in_item.row,
                                               i_in_item.col);
        mem_wr.wgt_addr = conv2d_pkg::wgt_addr(i_in_item.filter_index, i_in_item.channel,
                              conv2d_pkg::tap_index(i_in_item.tap_row, i_in_item.tap_col));
        mem_wr.img_we   = in_accept && (i_in_item.kind == conv2d_pkg::KIND_WR_PIXEL)
                       && ({1'b0, i_in_item.channel} < nc_eff)
                       && ({1'b0, i_in_item.row} < h_eff)
                       && ({1'b0, i_in_item.col} < w_eff);
        mem_wr.wgt_we   = in_accept && (i_in_item.kind == conv2d_pkg::KIND_WR_WEIGHT)
                       && ({1'b0, i_in_item.filter_index} < nf_eff)
                       && ({1'b0, i_in_item.channel} < nc_eff)
                       && (int'(i_in_item.tap_row) < conv2d_pkg::KERNEL_HEIGHT)
                       && (int'(i_in_item.tap_col) < conv2d_pkg::KERNEL_WIDTH);
    end

    assign req_bad = !(({1'b0, i_in_item.filter_index} < nf_eff)
                    && ({1'b0, i_in_item.row} < h_eff)
                    && ({1'b0, i_in_item.col} < w_eff));

    // Tap position; a negative value wraps and sets the top bit
    assign pr = {2'b00, r_req_row} + {5'b0, r_ki} - 7'(conv2d_pkg::KH_HALF);
    assign pc = {2'b00, r_req_col} + {5'b0, r_kj} - 7'(conv2d_pkg::KW_HALF);
    assign tap_ok = !pr[6] && (pr < {1'b0, h_eff}) && !pc[6] && (pc < {1'b0, w_eff});

    assign mem_rd.img_addr = conv2d_pkg::img_addr(r_chan, pr[4:0], pc[4:0]);
    assign mem_rd.wgt_addr = conv2d_pkg::wgt_addr(r_req_filter, r_chan, r_tap);

    assign last_tap  = (r_ki == 2'(conv2d_pkg::KERNEL_HEIGHT - 1))
                    && (r_kj == 2'(conv2d_pkg::KERNEL_WIDTH - 1));
    assign last_chan = ({1'b0, r_chan} == nc_eff - 7'd1);

    // Next state and sequencer outputs
    always_comb begin
        n_state      = r_state;
        n_chan       = r_chan;
        n_ki         = r_ki;
        n_kj         = r_kj;
        n_tap        = r_tap;
        n_drain      = r_drain;
        n_req_filter = r_req_filter;
        n_req_row    = r_req_row;
        n_req_col    = r_req_col;
        n_bad        = r_bad;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        issue        = 1'b0;
        mac_ctl.clear = 1'b0;
        unique case (r_state)
            conv2d_pkg::S_IDLE: begin
                if (in_accept && (i_in_item.kind == conv2d_pkg::KIND_COMPUTE)) begin
                    n_req_filter  = i_in_item.filter_index;
                    n_req_row     = i_in_item.row;
                    n_req_col     = i_in_item.col;
                    n_bad         = req_bad;
                    n_chan        = '0;
                    n_ki          = '0;
                    n_kj          = '0;
                    n_tap         = '0;
                    mac_ctl.clear = 1'b1;
                    n_state       = req_bad ? conv2d_pkg::S_DONE : conv2d_pkg::S_RUN;
                end
            end
            conv2d_pkg::S_RUN: begin
                // issue one tap, then advance column, row, channel
                issue = 1'b1;
                n_tap = r_tap + 4'd1;
                if (r_kj == 2'(conv2d_pkg::KERNEL_WIDTH - 1)) begin
                    n_kj = '0;
                    if (r_ki == 2'(conv2d_pkg::KERNEL_HEIGHT - 1)) begin
                        n_ki   = '0;
                        n_tap  = '0;
                        n_chan = r_chan + 6'd1;
                    end else begin
                        n_ki = r_ki + 2'd1;
                    end
                end else begin
                    n_kj = r_kj + 2'd1;
                end
                if (last_tap && last_chan) begin
                    n_drain = 1'b1;
                    n_state = conv2d_pkg::S_DRAIN;
                end
            end
            conv2d_pkg::S_DRAIN: begin
                // wait out the read and product stages
                if (!r_drain) begin
                    n_state = conv2d_pkg::S_DONE;
                end else begin
                    n_drain = 1'b0;
                end
            end
            conv2d_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_value   = r_bad ? '0 : mac_acc;
                    n_out.out_filter  = r_req_filter;
                    n_out.out_row     = r_req_row;
                    n_out.out_col     = r_req_col;
                    n_out.bad_request = r_bad;
                    n_out_valid       = 1'b1;
                    n_state           = conv2d_pkg::S_IDLE;
                end
            end
            default: n_state = conv2d_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= conv2d_pkg::S_IDLE;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_drain     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_p1_valid  <= issue && tap_ok;
            r_out_valid <= n_out_valid;
            r_drain     <= n_drain;
        end
    end

    // Counters and payload
    always_ff @(posedge i_clk) begin
        r_chan       <= n_chan;
        r_ki         <= n_ki;
        r_kj         <= n_kj;
        r_tap        <= n_tap;
        r_req_filter <= n_req_filter;
        r_req_row    <= n_req_row;
        r_req_col    <= n_req_col;
        r_bad        <= n_bad;
        r_out        <= n_out;
    end

    assign mac_ctl.valid = r_p1_valid;

    conv2d_store u_store (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_rd    (mem_rd),
        .o_img_q (img_q),
        .o_wgt_q (wgt_q)
    );

    conv2d_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_pixel  (img_q),
        .i_weight (wgt_q),
        .o_acc    (mac_acc),
        .o_busy   (mac_busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Pipeline must be empty when the sum is taken
    a_pipe_empty_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == conv2d_pkg::S_DONE) |-> (!r_p1_valid && !mac_busy))
        else $error("accumulate pipeline busy when result is taken");

    // Accumulator cleared by a compute request
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_item.kind == conv2d_pkg::KIND_COMPUTE)) |=> (mac_acc == '0))
        else $error("accumulator not cleared at request");

    // Linear tap number tracks kernel row and column
    a_tap_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == conv2d_pkg::S_RUN)
            |-> (r_tap == (4'(r_ki) * 4'(conv2d_pkg::KERNEL_WIDTH) + 4'(r_kj))))
        else $error("tap counter out of step with kernel position");

    // Flagged requests carry a zero sum
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.bad_request) |-> (o_out_item.out_value == '0))
        else $error("bad request with nonzero value");

    // No product in flight while idle
    a_no_stray_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == conv2d_pkg::S_IDLE) |-> !r_p1_valid)
        else $error("product issued outside a run");

endmodule

FILE: verif/conv2d_same_multichannel_tb.sv
// ----------------------------------------------------------------------------
// conv2d_same_multichannel_tb
// Self-checking bench for the 3x3 same-padded multichannel convolution.
// A directed plan covers field extremes, ignored writes and flagged requests.
// Random phases then run over several image, channel and filter settings.
// Before each in-range request the bench writes every pixel and weight that
// the request reads and that was never written. A local predictor computes
// each expected output pixel, and a scoreboard compares every result field
// by field. Both sides idle at random, and the receiver holds off once for
// a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module conv2d_same_multichannel_tb;
    import conv2d_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

    typedef struct {
        step_kind_e kind;
        t_in_item   item;
        logic [1:0] cfg_index;
        logic [6:0] cfg_data;
        bit         typed;
        t_out_item  result;
    } directed_step_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data = '0;

    // Predictor state: store contents, which entries hold data, and sizes
    logic signed [DATA_W-1:0] pixel_mem  [0:IMG_DEPTH-1];
    bit                       pixel_known[0:IMG_DEPTH-1];
    logic signed [DATA_W-1:0] weight_mem  [0:WGT_DEPTH-1];
    bit                       weight_known[0:WGT_DEPTH-1];
    int eff_w, eff_h, eff_nc, eff_nf;

    t_out_item expected_pixels[$];
    int fail_count = 0;
    int unsigned cycle_count = 0;

    // Idle control shared by the sender and the receiver
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int burst_left = 0;

    conv2d_same_multichannel DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: long hold when asked, otherwise random stall bursts
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (burst_left > 0) begin
            i_out_stall <= 1'b1;
            burst_left--;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            burst_left = $urandom_range(0, 6);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic void report_mismatch(string what, t_out_item want, t_out_item got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("MISMATCH %s: expected value %0d f %0d r %0d c %0d bad %0b",
                     what, want.out_value, want.out_filter, want.out_row, want.out_col,
                     want.bad_request);
            $display("          actual   value %0d f %0d r %0d c %0d bad %0b",
                     got.out_value, got.out_filter, got.out_row, got.out_col,
                     got.bad_request);
        end
    endfunction

    // Compare each result transfer with the oldest expected output pixel
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", '0, o_out_item);
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_item.out_value !== want.out_value ||
                    o_out_item.out_filter !== want.out_filter ||
                    o_out_item.out_row !== want.out_row ||
                    o_out_item.out_col !== want.out_col ||
                    o_out_item.bad_request !== want.bad_request) begin
                    report_mismatch("output pixel", want, o_out_item);
                end
            end
        end
    end

    function automatic int clamp_size(int raw, int maxv);
        if (raw < 1) return 1;
        if (raw > maxv) return maxv;
        return raw;
    endfunction

    function automatic int pixel_slot(int ch, int r, int c);
        return (ch * MAX_HEIGHT + r) * MAX_WIDTH + c;
    endfunction

    function automatic int weight_slot(int f, int ch, int tr, int tc);
        return ((f * MAX_IN_CHANNELS + ch) * KERNEL_HEIGHT + tr) * KERNEL_WIDTH + tc;
    endfunction

    function automatic void size_apply(logic [1:0] idx, logic [6:0] data);
        case (idx)
            CFG_IMAGE_WIDTH:  eff_w  = clamp_size(int'(data[5:0]), MAX_WIDTH);
            CFG_IMAGE_HEIGHT: eff_h  = clamp_size(int'(data[5:0]), MAX_HEIGHT);
            CFG_IN_CHANNELS:  eff_nc = clamp_size(int'(data), MAX_IN_CHANNELS);
            CFG_NUM_FILTERS:  eff_nf = clamp_size(int'(data), MAX_FILTERS);
            default: ;
        endcase
    endfunction

    function automatic bit request_in_range(t_in_item it);
        return it.filter_index < eff_nf && it.row < eff_h && it.col < eff_w;
    endfunction

    // Apply one item to the store copy; queue the output pixel of a request
    function automatic void conv_predict(t_in_item it);
        longint acc;
        t_out_item res;
        int pr, pc, slot;
        case (it.kind)
            KIND_WR_PIXEL: begin
                if (it.channel < eff_nc && it.row < eff_h && it.col < eff_w) begin
                    slot = pixel_slot(it.channel, it.row, it.col);
                    pixel_mem[slot] = it.value;
                    pixel_known[slot] = 1'b1;
                end
            end
            KIND_WR_WEIGHT: begin
                if (it.filter_index < eff_nf && it.channel < eff_nc &&
                    it.tap_row < KERNEL_HEIGHT && it.tap_col < KERNEL_WIDTH) begin
                    slot = weight_slot(it.filter_index, it.channel, it.tap_row, it.tap_col);
                    weight_mem[slot] = it.value;
                    weight_known[slot] = 1'b1;
                end
            end
            KIND_COMPUTE: begin
                acc = 0;
                res.bad_request = !request_in_range(it);
                if (!res.bad_request) begin
                    for (int d = 0; d < eff_nc; d++) begin
                        for (int ki = 0; ki < KERNEL_HEIGHT; ki++) begin
                            pr = int'(it.row) + ki - KH_HALF;
                            if (pr < 0 || pr >= eff_h) continue;
                            for (int kj = 0; kj < KERNEL_WIDTH; kj++) begin
                                pc = int'(it.col) + kj - KW_HALF;
                                if (pc < 0 || pc >= eff_w) continue;
                                acc += longint'(pixel_mem[pixel_slot(d, pr, pc)]) *
                                       longint'(weight_mem[weight_slot(it.filter_index,
                                                                       d, ki, kj)]);
                            end
                        end
                    end
                    // Saturate to the 42-bit output range
                    if (acc > (longint'(1) <<< (ACC_W - 1)) - 1)
                        acc = (longint'(1) <<< (ACC_W - 1)) - 1;
                    if (acc < -(longint'(1) <<< (ACC_W - 1)))
                        acc = -(longint'(1) <<< (ACC_W - 1));
                end
                res.out_value = acc[ACC_W-1:0];
                res.out_filter = it.filter_index;
                res.out_row = it.row;
                res.out_col = it.col;
                expected_pixels.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item make_item(logic [1:0] kind, int ch, int f, int r, int c,
                                           int tr, int tc, logic [15:0] v);
        t_in_item it;
        it.kind = kind;
        it.channel = 6'(ch);
        it.filter_index = 6'(f);
        it.row = 5'(r);
        it.col = 5'(c);
        it.tap_row = 2'(tr);
        it.tap_col = 2'(tc);
        it.value = v;
        return it;
    endfunction

    function automatic logic [15:0] random_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic; some out-of-range writes and requests and unused kinds
    function automatic t_in_item random_item();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return make_item(KIND_COMPUTE, $urandom_range(0, 63),
                             $urandom_range(0, eff_nf - 1), $urandom_range(0, eff_h - 1),
                             $urandom_range(0, eff_w - 1), $urandom_range(0, 3),
                             $urandom_range(0, 3), 16'($urandom));
        if (p < 65)
            return make_item(KIND_WR_PIXEL, $urandom_range(0, eff_nc - 1),
                             $urandom_range(0, 63), $urandom_range(0, eff_h - 1),
                             $urandom_range(0, eff_w - 1), $urandom_range(0, 3),
                             $urandom_range(0, 3), random_value());
        if (p < 80)
            return make_item(KIND_WR_WEIGHT, $urandom_range(0, eff_nc - 1),
                             $urandom_range(0, eff_nf - 1), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, KERNEL_HEIGHT - 1),
                             $urandom_range(0, KERNEL_WIDTH - 1), random_value());
        if (p < 95)
            return make_item(2'($urandom_range(0, 2)), $urandom_range(0, 63),
                             $urandom_range(0, 63), $urandom_range(0, 31),
                             $urandom_range(0, 31), $urandom_range(0, 3),
                             $urandom_range(0, 3), 16'($urandom));
        return make_item(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 3), $urandom_range(0, 3), 16'($urandom));
    endfunction

    // Offer one item, after an optional idle burst, and wait for its transfer
    task automatic push_item(t_in_item it);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        @(negedge i_clk);
    endtask

    task automatic issue(t_in_item it);
        conv_predict(it);
        push_item(it);
    endtask

    // Write every pixel and weight that a request reads and that holds no data
    task automatic fill_neighborhood(t_in_item req);
        int pr, pc;
        for (int d = 0; d < eff_nc; d++) begin
            for (int ki = 0; ki < KERNEL_HEIGHT; ki++) begin
                for (int kj = 0; kj < KERNEL_WIDTH; kj++) begin
                    pr = int'(req.row) + ki - KH_HALF;
                    pc = int'(req.col) + kj - KW_HALF;
                    if (pr >= 0 && pr < eff_h && pc >= 0 && pc < eff_w &&
                        !pixel_known[pixel_slot(d, pr, pc)])
                        issue(make_item(KIND_WR_PIXEL, d, 0, pr, pc, 0, 0, random_value()));
                    if (!weight_known[weight_slot(req.filter_index, d, ki, kj)])
                        issue(make_item(KIND_WR_WEIGHT, d, req.filter_index, 0, 0, ki, kj,
                                        random_value()));
                end
            end
        end
    endtask

    task automatic send_checked(t_in_item it);
        if (it.kind == KIND_COMPUTE && request_in_range(it))
            fill_neighborhood(it);
        issue(it);
    endtask

    // Drop valid, let every pending result arrive, then let writes settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Keep valid high on return; the caller lowers it after the last write
    task automatic cfg_write(logic [1:0] idx, logic [6:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        size_apply(idx, data);
        @(negedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int nc, int nf, int count, int gaps, int stalls,
                             bit hold);
        wait_idle();
        cfg_write(CFG_IMAGE_WIDTH, 7'(w));
        cfg_write(CFG_IMAGE_HEIGHT, 7'(h));
        cfg_write(CFG_IN_CHANNELS, 7'(nc));
        cfg_write(CFG_NUM_FILTERS, 7'(nf));
        i_cfg_valid <= 1'b0;
        gap_pct = gaps;
        stall_pct = stalls;
        if (hold) hold_asks++;
        repeat (count) send_checked(random_item());
    endtask

    function automatic directed_step_t item_step(t_in_item it);
        directed_step_t s;
        s = '{kind: STEP_ITEM, item: it, cfg_index: '0, cfg_data: '0, typed: 1'b0,
              result: '0};
        return s;
    endfunction

    // Out-of-range request: value zero, request echoed, flag set
    function automatic directed_step_t flagged_step(int f, int r, int c);
        directed_step_t s;
        s = item_step(make_item(KIND_COMPUTE, 0, f, r, c, 0, 0, 16'h0000));
        s.typed = 1'b1;
        s.result.out_value = '0;
        s.result.out_filter = 6'(f);
        s.result.out_row = 5'(r);
        s.result.out_col = 5'(c);
        s.result.bad_request = 1'b1;
        return s;
    endfunction

    function automatic directed_step_t cfg_step(logic [1:0] idx, logic [6:0] data);
        directed_step_t s;
        s = item_step('0);
        s.kind = STEP_CFG;
        s.cfg_index = idx;
        s.cfg_data = data;
        return s;
    endfunction

    initial begin
        directed_step_t plan[$];

        eff_w = clamp_size(int'(RST_IMAGE_WIDTH), MAX_WIDTH);
        eff_h = clamp_size(int'(RST_IMAGE_HEIGHT), MAX_HEIGHT);
        eff_nc = clamp_size(int'(RST_IN_CHANNELS), MAX_IN_CHANNELS);
        eff_nf = clamp_size(int'(RST_NUM_FILTERS), MAX_FILTERS);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan: corner request at reset sizes, then a 5x3 image
        plan.push_back(item_step(make_item(KIND_COMPUTE, 0, 63, 31, 31, 0, 0, 16'h0000)));
        plan.push_back(cfg_step(CFG_IMAGE_WIDTH, 7'd5));
        plan.push_back(cfg_step(CFG_IMAGE_HEIGHT, 7'd3));
        plan.push_back(cfg_step(CFG_IN_CHANNELS, 7'd2));
        plan.push_back(cfg_step(CFG_NUM_FILTERS, 7'd4));
        plan.push_back(item_step(make_item(KIND_WR_PIXEL, 0, 0, 0, 0, 0, 0, 16'h7FFF)));
        plan.push_back(item_step(make_item(KIND_WR_PIXEL, 1, 0, 0, 1, 0, 0, 16'h8000)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 0, 0, 0, 0, 1, 1, 16'h8000)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 1, 0, 0, 0, 1, 2, 16'h8000)));
        plan.push_back(item_step(make_item(KIND_WR_PIXEL, 1, 0, 2, 4, 0, 0, 16'h8000)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 1, 3, 0, 0, 1, 1, 16'h8000)));
        // Writes outside the configured sizes are dropped
        plan.push_back(item_step(make_item(KIND_WR_PIXEL, 63, 0, 31, 31, 0, 0, 16'hFFFF)));
        plan.push_back(item_step(make_item(KIND_WR_PIXEL, 0, 0, 3, 0, 0, 0, 16'h1234)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 0, 0, 0, 0, 3, 0, 16'h1234)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 0, 0, 0, 0, 0, 3, 16'h1234)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 0, 4, 0, 0, 0, 0, 16'h1234)));
        plan.push_back(item_step(make_item(KIND_WR_WEIGHT, 2, 0, 0, 0, 0, 0, 16'h1234)));
        plan.push_back(item_step(make_item(KIND_UNUSED, 63, 63, 31, 31, 3, 3, 16'hFFFF)));
        plan.push_back(item_step(make_item(KIND_COMPUTE, 0, 0, 0, 0, 0, 0, 16'h0000)));
        plan.push_back(item_step(make_item(KIND_COMPUTE, 0, 3, 2, 4, 0, 0, 16'h0000)));
        plan.push_back(flagged_step(63, 0, 0));
        plan.push_back(flagged_step(0, 31, 0));
        plan.push_back(flagged_step(0, 0, 31));
        plan.push_back(flagged_step(4, 3, 5));

        gap_pct = 30;
        stall_pct = 30;
        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) begin
                wait_idle();
                cfg_write(plan[i].cfg_index, plan[i].cfg_data);
                i_cfg_valid <= 1'b0;
            end else if (plan[i].typed) begin
                expected_pixels.push_back(plan[i].result);
                push_item(plan[i].item);
            end else begin
                send_checked(plan[i].item);
            end
        end

        // Random phases: small sizes, extremes, saturated register values
        run_phase(4, 4, 2, 3, 120, 25, 25, 1'b0);
        run_phase(32, 32, 1, 64, 100, 15, 15, 1'b0);
        run_phase(1, 1, 64, 1, 20, 20, 20, 1'b0);
        run_phase(0, 63, 0, 127, 80, 30, 10, 1'b0);
        run_phase(7, 5, 3, 2, 100, 0, 20, 1'b1);
        run_phase(40, 2, 100, 0, 30, 20, 20, 1'b0);
        run_phase(6, 6, 4, 8, 150, 0, 0, 1'b0);

        wait_idle();
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: conv2d_same_multichannel.f
src/conv2d_pkg.sv
src/conv2d_store.sv
src/conv2d_mac.sv
src/conv2d_same_multichannel.sv
verif/conv2d_same_multichannel_tb.sv
